>>> rtl/core/prt_pkg.sv
package prt_pkg;

	// Item kinds carried on the input tuser bit.
	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CLEAR = 1'b1
	} prt_op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_DUPLICATE  = 3'd1,
		ST_BEYOND_END = 3'd2,
		ST_END_SET    = 3'd3,
		ST_CAPACITY   = 3'd4
	} prt_status_t;

	typedef enum logic [1:0] {
		AS_OPEN = 2'd0,
		AS_GAPS = 2'd1,
		AS_DONE = 2'd2
	} prt_assembly_t;

	localparam int unsigned IdxW    = 32;
	localparam int unsigned IdW     = 32;
	localparam int unsigned MaskW   = 32;
	localparam int unsigned InDataW = 64;
	localparam int unsigned ResW    = 3 + 2 + IdW + MaskW;
	localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8;

	// First member lands in the highest bits, so status ends up at bit 0.
	typedef struct packed {
		logic [MaskW-1:0] present_mask;
		logic [IdW-1:0]   current_id;
		prt_assembly_t    assembly_state;
		prt_status_t      status;
	} prt_result_t;

endpackage

>>> rtl/core/prt_update.sv
module prt_update #(
	parameter int unsigned MAX_PARTS = 32,
	parameter int unsigned IW        = 5
) (
	input  logic [MAX_PARTS-1:0]  present,
	input  logic                  end_marked,
	input  logic [IW-1:0]         end_index,
	input  logic [prt_pkg::IdW-1:0] held_id,
	input  prt_pkg::prt_op_t      operation,
	input  logic [prt_pkg::IdxW-1:0] part_index,
	input  logic                  is_end,
	input  logic [prt_pkg::IdW-1:0] message_id,
	output logic [MAX_PARTS-1:0]  present_n,
	output logic                  end_marked_n,
	output logic [IW-1:0]         end_index_n,
	output logic [prt_pkg::IdW-1:0] held_id_n,
	output prt_pkg::prt_result_t  result
);
	import prt_pkg::*;

	localparam int unsigned PW = (MAX_PARTS < MaskW) ? MAX_PARTS : MaskW;

	// Bits 0 through last set, all others clear.
	function automatic logic [MAX_PARTS-1:0] prefix_mask(input logic [IW-1:0] last);
		logic [MAX_PARTS-1:0] m;
		for (int k = 0; k < MAX_PARTS; k++) begin
			m[k] = (IW'(k) <= last);
		end
		return m;
	endfunction

	logic                 in_range;
	logic [IW-1:0]        idx_lo;
	logic [MAX_PARTS-1:0] part_bit;
	logic                 hit;
	logic                 past_end;
	prt_status_t          status;
	prt_assembly_t        assembly;

	always_comb begin
		in_range = (part_index < IdxW'(MAX_PARTS));
		idx_lo   = part_index[IW-1:0];
		part_bit = in_range ? ({{(MAX_PARTS-1){1'b0}}, 1'b1} << idx_lo) : '0;
		hit      = |(present & part_bit);
		past_end = end_marked && (IdxW'(end_index) <= part_index);

		present_n    = present;
		end_marked_n = end_marked;
		end_index_n  = end_index;
		held_id_n    = held_id;
		status       = ST_OK;

		if (operation == OP_CLEAR) begin
			present_n    = '0;
			end_marked_n = 1'b0;
			end_index_n  = '0;
			held_id_n    = message_id;
		end else begin
			priority if (hit) begin
				status = ST_DUPLICATE;
			end else if (past_end) begin
				status = ST_BEYOND_END;
			end else if (end_marked && is_end) begin
				status = ST_END_SET;
			end else if (!in_range) begin
				status = ST_CAPACITY;
			end else if (is_end) begin
				// First end mark: drop anything that arrived above it.
				present_n    = (present | part_bit) & prefix_mask(idx_lo);
				end_marked_n = 1'b1;
				end_index_n  = idx_lo;
			end else begin
				present_n = present | part_bit;
			end
		end

		if (!end_marked_n) begin
			assembly = AS_OPEN;
		end else if (present_n == prefix_mask(end_index_n)) begin
			assembly = AS_DONE;
		end else begin
			assembly = AS_GAPS;
		end

		result.status         = status;
		result.assembly_state = assembly;
		result.current_id     = held_id_n;
		result.present_mask   = MaskW'(present_n[PW-1:0]);
	end

endmodule

>>> rtl/core/part_reassembly_tracker.sv
// An item is captured in the input register when accepted; its result goes to the
// result register, with the state update, once the output is free. Throughput: one item
// per cycle unless the output stalls; each item sees the state the previous one left.
// A stalled output holds one result while one more item waits in the input stage.
// Reset clears the bitmap, end mark, end index, id and both stage valid bits.
module part_reassembly_tracker #(
	parameter int unsigned MAX_PARTS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] part_index, [63:32] message_id
	input  logic [prt_pkg::InDataW-1:0]    s_axis_tdata,
	// [0] operation
	input  logic                           s_axis_tuser,
	// is_end
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [2:0] status, [4:3] assembly_state, [36:5] current_id,
	// [68:37] present_mask, [71:69] zero
	output logic [prt_pkg::OutDataW-1:0]   m_axis_tdata
);
	import prt_pkg::*;

	localparam int unsigned IW = $clog2(MAX_PARTS);

	logic                 valid_s1;
	prt_op_t              op_s1;
	logic [IdxW-1:0]      part_index_s1;
	logic                 is_end_s1;
	logic [IdW-1:0]       message_id_s1;

	logic                 valid_s2;
	prt_result_t          result_s2;

	logic [MAX_PARTS-1:0] present_q;
	logic                 end_marked_q;
	logic [IW-1:0]        end_index_q;
	logic [IdW-1:0]       held_id_q;

	logic [MAX_PARTS-1:0] present_n;
	logic                 end_marked_n;
	logic [IW-1:0]        end_index_n;
	logic [IdW-1:0]       held_id_n;
	prt_result_t          result_n;

	logic                 out_free;
	logic                 fire_s1;
	logic                 take_in;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1         <= prt_op_t'(s_axis_tuser);
			part_index_s1 <= s_axis_tdata[IdxW-1:0];
			is_end_s1     <= s_axis_tlast;
			message_id_s1 <= s_axis_tdata[InDataW-1:IdxW];
		end
	end

	prt_update #(
		.MAX_PARTS(MAX_PARTS),
		.IW       (IW)
	) u_update (
		.present     (present_q),
		.end_marked  (end_marked_q),
		.end_index   (end_index_q),
		.held_id     (held_id_q),
		.operation   (op_s1),
		.part_index  (part_index_s1),
		.is_end      (is_end_s1),
		.message_id  (message_id_s1),
		.present_n   (present_n),
		.end_marked_n(end_marked_n),
		.end_index_n (end_index_n),
		.held_id_n   (held_id_n),
		.result      (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			end_marked_q <= 1'b0;
			end_index_q  <= '0;
			held_id_q    <= '0;
		end else if (fire_s1) begin
			present_q    <= present_n;
			end_marked_q <= end_marked_n;
			end_index_q  <= end_index_n;
			held_id_q    <= held_id_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_s2 <= result_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OutDataW'(result_s2);

	// The end index only moves together with the end mark.
	a_end_index_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!end_marked_q |-> (end_index_q == '0))
		else $error("end index nonzero without an end mark");

	// Once the end is known, no part above it may be held.
	a_no_bits_above_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_marked_q |-> (((present_q >> end_index_q) >> 1) == '0))
		else $error("part held above the end index");

	// A clear item leaves an empty tracker behind it.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && op_s1 == OP_CLEAR) |=> (present_q == '0 && !end_marked_q))
		else $error("clear did not empty the tracker");

endmodule

>>> test/prt_checker.sv
module prt_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	// [31:0] part_index, [63:32] message_id
	input  logic [prt_pkg::InDataW-1:0]  s_axis_tdata,
	// [0] operation
	input  logic                         s_axis_tuser,
	// is_end
	input  logic                         s_axis_tlast,
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [2:0] status, [4:3] assembly_state, [36:5] current_id,
	// [68:37] present_mask, [71:69] zero
	input  logic [prt_pkg::OutDataW-1:0] m_axis_tdata,
	output int unsigned                  fails,
	output int unsigned                  pending,
	output int unsigned                  checked,
	output int unsigned                  completes
);
	timeunit 1ns;
	timeprecision 1ps;

	import prt_pkg::*;

	localparam int unsigned Parts = 32;

	logic [Parts-1:0] have_bits;
	logic             end_seen;
	logic [4:0]       last_idx;
	logic [IdW-1:0]   msg_id;
	prt_result_t      tracker_results_q[$];

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fails++;
		$display("mismatch at result %0d: %s is %0h, expected %0h", checked, what, got, want);
	endtask

	function automatic prt_assembly_t assembly_now();
		logic [Parts:0] prefix;
		if (!end_seen) begin
			return AS_OPEN;
		end
		prefix = ({{Parts{1'b0}}, 1'b1} << (last_idx + 1)) - 1'b1;
		return (have_bits == prefix[Parts-1:0]) ? AS_DONE : AS_GAPS;
	endfunction

	// Applies one item to the shadow tracker and returns the result it should give.
	function automatic prt_result_t track_part(prt_op_t op, logic [31:0] idx, logic last,
			logic [31:0] id);
		prt_result_t r;
		prt_status_t st;
		logic        in_range;
		int          b;
		st = ST_OK;
		in_range = (idx < Parts);
		if (op == OP_CLEAR) begin
			have_bits = '0;
			end_seen = 1'b0;
			last_idx = '0;
			msg_id = id;
		end else if (in_range && have_bits[idx[4:0]]) begin
			st = ST_DUPLICATE;
		end else if (end_seen && idx >= {27'd0, last_idx}) begin
			st = ST_BEYOND_END;
		end else if (end_seen && last) begin
			st = ST_END_SET;
		end else if (!in_range) begin
			st = ST_CAPACITY;
		end else begin
			have_bits[idx[4:0]] = 1'b1;
			if (!end_seen && last) begin
				// The first end mark drops every part numbered above it.
				end_seen = 1'b1;
				last_idx = idx[4:0];
				for (b = 0; b < Parts; b++) begin
					if (b > last_idx) have_bits[b] = 1'b0;
				end
			end
		end
		r.status = st;
		r.assembly_state = assembly_now();
		r.current_id = msg_id;
		r.present_mask = have_bits;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		prt_result_t got;
		prt_result_t want;
		if (!arst_n) begin
			have_bits = '0;
			end_seen = 1'b0;
			last_idx = '0;
			msg_id = '0;
			tracker_results_q.delete();
			fails = 0;
			checked = 0;
			completes = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = prt_result_t'(m_axis_tdata[ResW-1:0]);
				if (m_axis_tdata[OutDataW-1:ResW] != '0) begin
					report_mismatch("padding", 32'(m_axis_tdata[OutDataW-1:ResW]), 32'd0);
				end
				if (tracker_results_q.size() == 0) begin
					report_mismatch("result with nothing outstanding, status", 32'(got.status),
						32'd0);
				end else begin
					want = tracker_results_q.pop_front();
					if (got.status != want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.assembly_state != want.assembly_state)
						report_mismatch("assembly_state", 32'(got.assembly_state),
							32'(want.assembly_state));
					if (got.current_id != want.current_id)
						report_mismatch("current_id", got.current_id, want.current_id);
					if (got.present_mask != want.present_mask)
						report_mismatch("present_mask", got.present_mask, want.present_mask);
					if (want.assembly_state == AS_DONE) completes++;
				end
				checked++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				tracker_results_q.push_back(track_part(prt_op_t'(s_axis_tuser),
					s_axis_tdata[31:0], s_axis_tlast, s_axis_tdata[63:32]));
			end
			pending = tracker_results_q.size();
		end
	end

endmodule

>>> test/tb_part_reassembly_tracker.sv
module tb_part_reassembly_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import prt_pkg::*;

	typedef enum int unsigned {
		NZ_DUP,
		NZ_BEYOND,
		NZ_END_AGAIN,
		NZ_WILD
	} noise_kind_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic                s_axis_tuser;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;

	int unsigned fails;
	int unsigned pending;
	int unsigned checked;
	int unsigned completes;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned items_sent;
	bit          hold_req;
	int unsigned hold_len;

	part_reassembly_tracker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	prt_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fails         (fails),
		.pending       (pending),
		.checked       (checked),
		.completes     (completes)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", pending);
		$display("status: fail");
		$finish;
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = hold_len;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(prt_op_t op, logic [31:0] idx, logic last, logic [31:0] id);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {id, idx};
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [31:0] pick_index();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(40);
			default: return $urandom_range(31);
		endcase
	endfunction

	task automatic send_noise(int unsigned len, int unsigned sent, const ref int unsigned order[32]);
		noise_kind_t kind;
		kind = noise_kind_t'($urandom_range(3));
		case (kind)
			NZ_DUP: begin
				if (sent != 0) send_item(OP_ADD, order[$urandom_range(sent - 1)], 1'b0, $urandom);
				else send_item(OP_ADD, pick_index(), 1'b0, $urandom);
			end
			NZ_BEYOND: send_item(OP_ADD, len + $urandom_range(8), 1'($urandom_range(1)),
				$urandom);
			NZ_END_AGAIN: send_item(OP_ADD, $urandom_range(31), 1'b1, $urandom);
			default: send_item(OP_ADD, pick_index(), 1'($urandom_range(1)), $urandom);
		endcase
	endtask

	// One message: a clear, then its parts in shuffled order with the highest-numbered part
	// carrying the end mark, and now and then a stray or broken item mixed in.
	task automatic run_message();
		int unsigned order[32];
		int unsigned len;
		int unsigned i;
		int unsigned j;
		int unsigned tmp;
		len = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
		for (i = 0; i < 32; i++) order[i] = i;
		for (i = len - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		send_item(OP_CLEAR, pick_index(), 1'($urandom_range(1)), $urandom);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 15) send_noise(len, i, order);
			send_item(OP_ADD, order[i], (order[i] == len - 1), $urandom);
		end
		if ($urandom_range(99) < 30) send_noise(len, len, order);
	endtask

	initial begin
		int unsigned phase;
		int unsigned target;
		int unsigned waited;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ADD;
		s_axis_tlast = 1'b0;
		hold_req = 1'b0;
		hold_len = 0;
		items_sent = 0;
		send_idle_pct = 7;
		recv_idle_pct = 84;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every status, both end cases, and the index and id extremes.
		send_item(OP_ADD, 32'd0, 1'b0, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'd0, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd31, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd32, 1'b0, 32'd0);
		send_item(OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'd0);
		send_item(OP_ADD, 32'd5, 1'b1, 32'd0);
		send_item(OP_ADD, 32'd5, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd6, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd40, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd2, 1'b1, 32'd0);
		send_item(OP_ADD, 32'd1, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd2, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd3, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd4, 1'b0, 32'd0);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'd0, 1'b1, 32'd0);
		send_item(OP_ADD, 32'hFFFF_FFFF, 1'b0, 32'd0);
		send_item(OP_CLEAR, 32'd0, 1'b0, 32'd0);
		send_item(OP_ADD, 32'd31, 1'b1, 32'd0);
		send_item(OP_ADD, 32'd30, 1'b0, 32'd0);
		send_item(OP_CLEAR, 32'd0, 1'b0, 32'hA5A5_5A5A);
		send_item(OP_ADD, 32'h8000_0000, 1'b0, 32'h5A5A_A5A5);
		pause_until_drained();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase != 1) begin
				// Long receiver hold-off while the sender keeps offering items.
				hold_len = 150 + $urandom_range(100);
				hold_req = 1'b1;
			end
			target = items_sent + 380;
			while (items_sent < target) begin
				if ($urandom_range(99) < 85) begin
					run_message();
				end else begin
					send_item(($urandom_range(7) == 0) ? OP_CLEAR : OP_ADD, pick_index(),
						1'($urandom_range(1)), $urandom);
				end
			end
			pause_until_drained();
		end

		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		$display("covered %0d items under three idle mixes with receiver hold-offs;",
			items_sent);
		$display("%0d results compared, %0d of them complete assemblies, %0d mismatches",
			checked, completes, fails);
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/prt_pkg.sv
rtl/core/prt_update.sv
rtl/core/part_reassembly_tracker.sv
test/prt_checker.sv
test/tb_part_reassembly_tracker.sv
